FILE: sv/sort_combine_like_terms_defines.svh
// Assertion macros shared by the checking code of the polynomial normaliser.
`ifndef SORT_COMBINE_LIKE_TERMS_DEFINES_SVH
`define SORT_COMBINE_LIKE_TERMS_DEFINES_SVH
`ifndef SYNTHESIS
`define SCL_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SCL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCL_ASSERT_SAME(name, ante, cons, msg)
`define SCL_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: sv/scl_pkg.sv
package scl_pkg;

	localparam int DEG_W         = 8;
	localparam int COEF_W        = 32;
	localparam int MAX_TERMS_DEF = 64;

	typedef struct packed {
		logic [DEG_W-1:0]         term_degree;
		logic signed [COEF_W-1:0] term_coefficient;
		logic                     last_term;
	} term_in_t;

	typedef struct packed {
		logic [DEG_W-1:0]         out_degree;
		logic signed [COEF_W-1:0] out_coefficient;
		logic                     out_last;
		logic                     overflow;
	} result_t;

	typedef struct packed {
		logic [DEG_W-1:0]         degree;
		logic signed [COEF_W-1:0] coefficient;
	} entry_t;

	typedef struct packed {
		logic   load;
		logic   insert;
		logic   shift_out;
		entry_t term;
	} cell_ctrl_t;

endpackage

FILE: sv/scl_stream_if.sv
interface scl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/scl_cell.sv
module scl_cell import scl_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       valid,
	input  logic       left_gt,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       gt,
	output logic       eq
);

	entry_t entry_q;

	function automatic logic signed [COEF_W-1:0] sat_add(
		input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b
	);
		logic signed [COEF_W:0] s;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		if (s[COEF_W] != s[COEF_W-1]) begin
			sat_add = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			sat_add = s[COEF_W-1:0];
		end
	endfunction

	assign entry = entry_q;
	assign gt    = valid && (entry_q.degree > ctrl.term.degree);
	assign eq    = valid && (entry_q.degree == ctrl.term.degree);

	// Cells left of the insertion point hold, the first cell not above the new degree takes
	// the new term and every cell to its right takes its left neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.shift_out) begin
			entry_q <= right_entry;
		end else if (ctrl.insert) begin
			if (!left_gt) begin
				entry_q <= left_entry;
			end else if (!gt) begin
				entry_q <= ctrl.term;
			end
		end else if (ctrl.load && eq) begin
			entry_q.coefficient <= sat_add(entry_q.coefficient, ctrl.term.coefficient);
		end
	end

endmodule

FILE: sv/sort_combine_like_terms.sv
// Each term transfer is absorbed by the cell row; terms load at one per cycle outside emission.
// After the transfer that carries last_term the combined terms leave from the head cell, one
// per cycle while the sink is ready, starting the next cycle.
// No term is taken while the row empties. Reset clears the term count, the drop flag and
// the state; the cell contents are not reset and are never read before they are written.
`include "sort_combine_like_terms_defines.svh"

module sort_combine_like_terms import scl_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	scl_stream_if.sink   term,
	scl_stream_if.source result
);

	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic               dropped_q;

	entry_t             cell_entry [MAX_TERMS];
	logic [MAX_TERMS-1:0] cell_gt;
	logic [MAX_TERMS-1:0] cell_eq;
	logic [MAX_TERMS-1:0] cell_valid;
	cell_ctrl_t         ctrl;
	term_in_t           term_in;
	result_t            result_out;

	logic term_xfer;
	logic result_xfer;
	logic any_eq;
	logic full;
	logic do_insert;

	assign term_in     = term.payload;
	assign term.ready  = (state_q == ST_LOAD);
	assign result.valid = (state_q == ST_EMIT);
	assign term_xfer   = term.valid && term.ready;
	assign result_xfer = result.valid && result.ready;

	assign any_eq    = |cell_eq;
	assign full      = (count_q == CNT_W'(MAX_TERMS));
	assign do_insert = !any_eq && !full;

	assign ctrl.load             = term_xfer;
	assign ctrl.insert           = term_xfer && do_insert;
	assign ctrl.shift_out        = result_xfer;
	assign ctrl.term.degree      = term_in.term_degree;
	assign ctrl.term.coefficient = term_in.term_coefficient;

	for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
		logic   left_gt;
		entry_t left_entry;
		entry_t right_entry;

		assign cell_valid[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_gt    = 1'b1;
			assign left_entry = ctrl.term;
		end else begin : g_body
			assign left_gt    = cell_gt[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == MAX_TERMS - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		scl_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (cell_valid[i]),
			.left_gt     (left_gt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i]),
			.eq          (cell_eq[i])
		);
	end

	assign result_out.out_degree      = cell_entry[0].degree;
	assign result_out.out_coefficient = cell_entry[0].coefficient;
	assign result_out.out_last        = (count_q == CNT_W'(1));
	assign result_out.overflow        = dropped_q;
	assign result.payload             = result_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (term_xfer) begin
						if (do_insert) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (!any_eq && full) begin
							dropped_q <= 1'b1;
						end
						if (term_in.last_term) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (result_xfer) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`SCL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_TERMS), "term count beyond capacity")
	`SCL_ASSERT_SAME(a_sorted_head, count_q >= CNT_W'(2), cell_entry[0].degree > cell_entry[1].degree, "head cells out of order")
	`SCL_ASSERT_NEXT(a_last_starts_emit, term_xfer && term_in.last_term, state_q == ST_EMIT && count_q != '0, "last term did not start emission")
	`SCL_ASSERT_NEXT(a_combine_keeps_count, term_xfer && any_eq, $stable(count_q), "combined term changed the count")
	`SCL_ASSERT_NEXT(a_final_clears, result_xfer && result_out.out_last, state_q == ST_LOAD && count_q == '0 && !dropped_q, "final transfer did not clear the row")

endmodule
